// ----- hdl/mmh2_pkg.sv -----
// ----------------------------------------------------------------------------
// mmh2_pkg
// Shared constants, types and helpers for the MurmurHash2 stream hasher.
// ----------------------------------------------------------------------------
package mmh2_pkg;

  // mixing multiplier and shift amounts
  localparam logic [31:0] MixMul     = 32'h5bd1e995;
  localparam int unsigned MixShift   = 24;
  localparam int unsigned FinShiftA  = 13;
  localparam int unsigned FinShiftB  = 15;
  localparam logic [31:0] SeedReset  = 32'hDEADBABE;

  // stream payload layout
  localparam int unsigned WordW   = 32;
  localparam int unsigned CountW  = 3;
  localparam int unsigned LenW    = 32;
  localparam int unsigned InDataW = 72;

  // register map
  localparam logic [0:0] RegHashSeed = 1'b0;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // item accepted and live
    logic kmul1;     // k = k * M
    logic kmul2;     // k = (k ^ k >> 24) * M
    logic hmix;      // h = h * M ^ k
    logic tmix;      // h = (h ^ tail) * M
    logic fin;       // k = (h ^ h >> 13) * M
    logic out_load;  // result = k ^ k >> 15
  } mmh2_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic item_first;
    logic item_last;
    logic item_full;
    logic item_tail;
    logic last_q;
  } mmh2_stat_t;

  // byte mask for a one to three byte tail
  function automatic logic [31:0] tail_mask(input logic [1:0] n);
    logic [31:0] m;
    case (n)
      2'd1:    m = 32'h0000_00FF;
      2'd2:    m = 32'h0000_FFFF;
      default: m = 32'h00FF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// ----- hdl/mmh2_ctrl.sv -----
// ----------------------------------------------------------------------------
// mmh2_ctrl
// Sequencer: steps each item through the shared multiplier and owns the
// message and result-valid flags.
// ----------------------------------------------------------------------------
module mmh2_ctrl import mmh2_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  mmh2_stat_t stat_i,
  output mmh2_cmd_t  cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StKMul1 = 3'd1;
  localparam logic [2:0] StKMul2 = 3'd2;
  localparam logic [2:0] StHMix  = 3'd3;
  localparam logic [2:0] StTail  = 3'd4;
  localparam logic [2:0] StFin1  = 3'd5;
  localparam logic [2:0] StFin2  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       in_msg_q, in_msg_d;
  logic       out_valid_q, out_valid_d;
  logic       live;

  // an item counts only if it opens a message or one is open
  assign live       = stat_i.item_first | in_msg_q;
  assign in_ready_o = (state_q == StIdle);

  // next state and commands
  always_comb begin
    state_d  = state_q;
    in_msg_d = in_msg_q;
    cmd_o    = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i && live) begin
          cmd_o.load = 1'b1;
          in_msg_d   = ~stat_i.item_last;
          if (stat_i.item_full) begin
            state_d = StKMul1;
          end else if (stat_i.item_tail) begin
            state_d = StTail;
          end else if (stat_i.item_last) begin
            state_d = StFin1;
          end
        end
      end
      StKMul1: begin
        cmd_o.kmul1 = 1'b1;
        state_d     = StKMul2;
      end
      StKMul2: begin
        cmd_o.kmul2 = 1'b1;
        state_d     = StHMix;
      end
      StHMix: begin
        cmd_o.hmix = 1'b1;
        state_d    = stat_i.last_q ? StFin1 : StIdle;
      end
      StTail: begin
        cmd_o.tmix = 1'b1;
        state_d    = stat_i.last_q ? StFin1 : StIdle;
      end
      StFin1: begin
        cmd_o.fin = 1'b1;
        state_d   = StFin2;
      end
      StFin2: begin
        // hold the finished value until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // result valid flag
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      in_msg_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_msg_q    <= in_msg_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- hdl/mmh2_dp.sv -----
// ----------------------------------------------------------------------------
// mmh2_dp
// Datapath: hash and word registers around one shared multiply-by-M unit,
// plus the result register.
// ----------------------------------------------------------------------------
module mmh2_dp import mmh2_pkg::*; (
  input  logic              clk_i,
  input  logic [WordW-1:0]  word_i,
  input  logic [CountW-1:0] count_i,
  input  logic              first_i,
  input  logic              last_i,
  input  logic [LenW-1:0]   length_i,
  input  logic [31:0]       seed_i,
  input  mmh2_cmd_t         cmd_i,
  output mmh2_stat_t        stat_o,
  output logic [31:0]       hash_o
);

  logic [31:0] h_q, h_d;
  logic [31:0] k_q, k_d;
  logic [31:0] mask_q;
  logic [31:0] out_q;
  logic        last_q;
  logic [31:0] mul_a;
  logic [31:0] prod;
  logic        in_full, in_tail;

  // counts of five to seven behave as a full word
  assign in_full = count_i[2];
  assign in_tail = ~count_i[2] & (count_i[1:0] != 2'd0);

  assign stat_o.item_first = first_i;
  assign stat_o.item_last  = last_i;
  assign stat_o.item_full  = in_full;
  assign stat_o.item_tail  = in_tail;
  assign stat_o.last_q     = last_q;

  // shared multiplier operand select
  always_comb begin
    case (1'b1)
      cmd_i.kmul2: mul_a = k_q ^ (k_q >> MixShift);
      cmd_i.hmix:  mul_a = h_q;
      cmd_i.tmix:  mul_a = h_q ^ (k_q & mask_q);
      cmd_i.fin:   mul_a = h_q ^ (h_q >> FinShiftA);
      default:     mul_a = k_q;
    endcase
  end

  assign prod = mul_a * MixMul;

  // register updates
  always_comb begin
    h_d = h_q;
    k_d = k_q;
    if (cmd_i.load) begin
      k_d = word_i;
      if (first_i) begin
        h_d = seed_i ^ length_i;
      end
    end
    if (cmd_i.kmul1 || cmd_i.kmul2 || cmd_i.fin) begin
      k_d = prod;
    end
    if (cmd_i.hmix) begin
      h_d = prod ^ k_q;
    end
    if (cmd_i.tmix) begin
      h_d = prod;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;
    k_q <= k_d;
    if (cmd_i.load) begin
      last_q <= last_i;
      mask_q <= tail_mask(count_i[1:0]);
    end
    if (cmd_i.out_load) begin
      out_q <= k_q ^ (k_q >> FinShiftB);
    end
  end

  assign hash_o = out_q;

endmodule

// ----- hdl/murmur2_hash_stream.sv -----
// ----------------------------------------------------------------------------
// murmur2_hash_stream
// Endian-neutral 32-bit MurmurHash2 over a stream of message words.
// ----------------------------------------------------------------------------
// Input stream (s_axis): one item per message word. tdata carries the word,
// its valid byte count and, on the first item, the message length; tuser
// marks the first item, tlast the final one. Items arriving with no message
// open and no first flag are dropped.
// Output stream (m_axis): one 32-bit hash per message, after its last item.
// Config (APB): hash_seed at address 0, reset 0xDEADBABE; write only while
// the block is idle. pready is tied high.
// Sequence: one multiplier by M is shared by every step. A full word is
// accepted and passes three multiplies (KMul1, KMul2, HMix), a tail is
// accepted and mixed in Tail, an empty item only accepted. The last item then
// finalises (Fin1, Fin2) into the output register. One item is in work at a time.
// Reset clears the message and result-valid flags; the seed returns to its
// default. When the receiver stalls, the finished hash stays in the output
// register and the next message may still be accepted and mixed; only its
// own finalisation waits for the register to drain.
// ----------------------------------------------------------------------------
module murmur2_hash_stream import mmh2_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input stream
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [InDataW-1:0] s_axis_tdata_i,  // data_word, byte_count, message_length
  input  logic               s_axis_tuser_i,  // first_item
  input  logic               s_axis_tlast_i,  // last_item
  // output stream
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [31:0]        m_axis_tdata_o,  // hash_value
  // configuration
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [2:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  output logic [31:0]        prdata_o,
  output logic               pready_o
);

  mmh2_cmd_t   cmd;
  mmh2_stat_t  stat;
  logic [31:0] seed_q;
  logic        cfg_wr;

  // configuration register
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i & penable_i & pwrite_i & (paddr_i[2] == RegHashSeed);
  assign prdata_o = (paddr_i[2] == RegHashSeed) ? seed_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SeedReset;
    end else if (cfg_wr) begin
      seed_q <= pwdata_i;
    end
  end

  mmh2_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mmh2_dp u_dp (
    .clk_i    (clk_i),
    .word_i   (s_axis_tdata_i[WordW-1:0]),
    .count_i  (s_axis_tdata_i[WordW+CountW-1:WordW]),
    .first_i  (s_axis_tuser_i),
    .last_i   (s_axis_tlast_i),
    .length_i (s_axis_tdata_i[WordW+CountW+LenW-1:WordW+CountW]),
    .seed_i   (seed_q),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .hash_o   (m_axis_tdata_o)
  );

  // the shared multiplier serves one step at a time
  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.kmul1, cmd.kmul2, cmd.hmix, cmd.tmix, cmd.fin, cmd.out_load}))
    else $error("more than one datapath step in one cycle");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result register overwritten before it was taken");

  // a result only appears after a finalisation load
  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(cmd.out_load))
    else $error("result valid without a finished hash");

  // items are taken only while the sequencer is free
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> s_axis_tready_o && s_axis_tvalid_i)
    else $error("item loaded without a handshake");

endmodule
